// ===== rtl/fhpp_pkg.sv =====
// ----------------------------------------------------------------------------
// fhpp_pkg
// Shared constants and types of the framed height packet parser.
// ----------------------------------------------------------------------------
package fhpp_pkg;

   localparam logic [7:0] START_CODE = 8'h68;
   localparam logic [7:0] FIXED_CODE = 8'h01;
   localparam logic [7:0] END_CODE   = 8'h16;

   typedef enum logic [1:0] {
      STATUS_GOOD  = 2'd0,
      STATUS_FIXED = 2'd1,
      STATUS_SUM   = 2'd2,
      STATUS_END   = 2'd3
   } status_type;

   // One parser decision: whether a result is produced, and its fields
   typedef struct packed {
      logic        emit;
      status_type  status;
      logic [15:0] height;
   } result_type;

endpackage

// ===== rtl/fhpp_parse.sv =====
// ----------------------------------------------------------------------------
// fhpp_parse
// Frame state, running checksum and height capture; one byte per step.
// ----------------------------------------------------------------------------
module fhpp_parse
   import fhpp_pkg::*;
#(
   parameter int BODY_LEN   = 3,
   parameter int HEIGHT_POS = 1
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   input  logic       rearm,
   output result_type result
);

   localparam int PHASE_W = $clog2(BODY_LEN + 4);

   localparam logic [PHASE_W-1:0] PH_HUNT  = PHASE_W'(0);
   localparam logic [PHASE_W-1:0] PH_FIXED = PHASE_W'(1);
   localparam logic [PHASE_W-1:0] PH_BODY  = PHASE_W'(2);
   localparam logic [PHASE_W-1:0] PH_SUM   = PHASE_W'(BODY_LEN + 2);
   localparam logic [PHASE_W-1:0] PH_END   = PHASE_W'(BODY_LEN + 3);

   // Height bytes that fall outside the body are never captured
   localparam bit HI_IN = (HEIGHT_POS < BODY_LEN);
   localparam bit LO_IN = (HEIGHT_POS + 1 < BODY_LEN);
   localparam logic [PHASE_W-1:0] PH_HI = HI_IN ? PHASE_W'(HEIGHT_POS + 2) : PH_HUNT;
   localparam logic [PHASE_W-1:0] PH_LO = LO_IN ? PHASE_W'(HEIGHT_POS + 3) : PH_HUNT;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [7:0]         sum_ff, sum_in;
   logic [15:0]        height_ff, height_in;
   logic               armed_ff, armed_in;
   logic               armed_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         sum_ff    <= '0;
         height_ff <= '0;
         armed_ff  <= 1'b1;
      end else if (step) begin
         phase_ff  <= phase_in;
         sum_ff    <= sum_in;
         height_ff <= height_in;
         armed_ff  <= armed_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      sum_in        = sum_ff;
      height_in     = height_ff;
      armed_now     = armed_ff | rearm;
      armed_in      = armed_now;
      result.emit   = 1'b0;
      result.status = STATUS_GOOD;
      result.height = '0;

      if (armed_now) begin
         if (phase_ff == PH_FIXED) begin
            if (rx_byte != FIXED_CODE) begin
               phase_in      = PH_HUNT;
               result.emit   = 1'b1;
               result.status = STATUS_FIXED;
            end else begin
               sum_in   = rx_byte;
               phase_in = PH_BODY;
            end
         end else if (phase_ff >= PH_BODY && phase_ff < PH_SUM) begin
            sum_in = sum_ff + rx_byte;
            if (HI_IN && phase_ff == PH_HI) begin
               height_in[15:8] = rx_byte;
            end else if (LO_IN && phase_ff == PH_LO) begin
               height_in[7:0] = rx_byte;
            end
            phase_in = phase_ff + PHASE_W'(1);
         end else if (phase_ff == PH_SUM) begin
            if (rx_byte != sum_ff) begin
               phase_in      = PH_HUNT;
               result.emit   = 1'b1;
               result.status = STATUS_SUM;
            end else begin
               phase_in = PH_END;
            end
         end else if (phase_ff == PH_END) begin
            phase_in    = PH_HUNT;
            result.emit = 1'b1;
            if (rx_byte != END_CODE) begin
               result.status = STATUS_END;
            end else begin
               armed_in      = 1'b0;
               result.status = STATUS_GOOD;
               result.height = height_ff;
            end
         end else begin
            // hunt, also from any unused phase value
            phase_in = PH_HUNT;
            if (rx_byte == START_CODE) begin
               phase_in  = PH_FIXED;
               sum_in    = '0;
               height_in = '0;
            end
         end
      end
   end

endmodule

// ===== rtl/framed_height_packet_parser.sv =====
// ----------------------------------------------------------------------------
// framed_height_packet_parser
// Frames 0x68 / 0x01 / body / checksum / 0x16 packets from a byte stream.
// ----------------------------------------------------------------------------
// Use: feed received bytes on the req_ channel, one per transfer, with
// req_tuser set on a byte to re-enable reception after a good packet. Each
// packet outcome leaves as one transfer on the rsp_ channel: status in
// rsp_tuser, height in rsp_tdata (zero unless status is good). Bytes that
// end no packet produce nothing.
// Throughput: one byte per cycle while no held result is stalled by the
// receiver. A byte is held in the input register, is parsed as it moves on,
// and its result is registered in the output register.
// When the receiver stalls, the held result blocks parsing; the input
// register still takes one more byte, then req_tready falls until the
// result is taken.
// Reset empties both registers, returns the parser to hunting for the start
// byte, clears the checksum and height, and arms reception.
// ----------------------------------------------------------------------------
module framed_height_packet_parser
   import fhpp_pkg::*;
#(
   parameter int BODY_LEN   = 3,
   parameter int HEIGHT_POS = 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [0:0]  req_tuser,   // [0] rearm
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] height
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_rearm_ff;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_height_ff;
   status_type  out_status_ff;
   logic        advance;
   result_type  result;

   // Parse the held byte when the output register is free or being emptied, result or not
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   fhpp_parse #(
      .BODY_LEN   (BODY_LEN),
      .HEIGHT_POS (HEIGHT_POS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .rearm   (in_rearm_ff),
      .result  (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = result.emit;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata;
         in_rearm_ff <= req_tuser[0];
      end
      if (advance && result.emit) begin
         out_status_ff <= result.status;
         out_height_ff <= result.height;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_height_ff;
   assign rsp_tuser  = out_status_ff;

endmodule

// ===== tb/sv/framed_height_packet_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// framed_height_packet_parser_tb
// Self-checking bench for the framed height packet parser.
// ----------------------------------------------------------------------------
// Drives a byte stream of whole frames, corrupted frames and noise into the
// req_ channel, predicts every packet outcome, and compares each rsp_
// transfer with the oldest predicted outcome. The sender works in random
// bursts and the receiver stalls on its own pattern, with stretches of both
// running flat out.
// ----------------------------------------------------------------------------
module framed_height_packet_parser_tb;
   import fhpp_pkg::*;

   localparam int BODY_LEN   = 3;
   localparam int HEIGHT_POS = 1;

   localparam int PH_HUNT  = 0;
   localparam int PH_FIXED = 1;
   localparam int PH_BODY  = 2;
   localparam int PH_SUM   = BODY_LEN + 2;
   localparam int PH_END   = BODY_LEN + 3;

   typedef struct {
      status_type  status;
      logic [15:0] height;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] rx_byte
   logic [0:0]  req_tuser = 1'b0;    // [0] rearm
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [15:0] height
   logic [1:0]  rsp_tuser;           // [1:0] status

   // Parser mirror
   int          parse_phase  = PH_HUNT;
   logic [7:0]  parse_sum    = 8'h00;
   logic [15:0] parse_height = 16'h0000;
   logic        parse_armed  = 1'b1;

   outcome_type expected_outcomes[$];
   int          sent_count  = 0;
   int          error_count = 0;

   // Traffic shaping
   bit          sender_gaps   = 1'b0;
   bit          rsp_stalls    = 1'b0;
   int          burst_left    = 0;
   int          ready_hold    = 0;
   int          rearm_percent = 0;

   framed_height_packet_parser #(
      .BODY_LEN   (BODY_LEN),
      .HEIGHT_POS (HEIGHT_POS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("Some tests failed");
      $finish;
   end

   // Receiver back-pressure: with stalls on, hold each ready level for a random stretch
   always @(negedge clock) begin
      if (ready_hold == 0) begin
         if (rsp_stalls) begin
            rsp_tready = ($urandom_range(0, 2) != 0);
            ready_hold = rsp_tready ? $urandom_range(1, 12) : $urandom_range(1, 9);
         end else begin
            rsp_tready = 1'b1;
            ready_hold = 1;
         end
      end
      ready_hold--;
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_outcomes.size() == 0) begin
            $error("unexpected result: status %0d, height %0h", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata !== want.height) begin
               $error("height: expected %0h, actual %0h", want.height, rsp_tdata);
               error_count++;
            end
         end
      end
   end

   task automatic predict_parse(input logic [7:0] rx_byte, input logic rearm);
      outcome_type outcome;
      bit          emit;
      int          body_idx;
      emit = 1'b0;
      outcome.height = 16'h0000;
      sent_count++;
      if (rearm)
         parse_armed = 1'b1;
      if (!parse_armed)
         return;
      if (parse_phase == PH_FIXED) begin
         if (rx_byte != FIXED_CODE) begin
            parse_phase = PH_HUNT;
            outcome.status = STATUS_FIXED;
            emit = 1'b1;
         end else begin
            parse_sum = rx_byte;
            parse_phase = PH_BODY;
         end
      end else if (parse_phase >= PH_BODY && parse_phase < PH_SUM) begin
         body_idx = parse_phase - PH_BODY;
         parse_sum = parse_sum + rx_byte;
         if (body_idx == HEIGHT_POS)
            parse_height[15:8] = rx_byte;
         else if (body_idx == HEIGHT_POS + 1)
            parse_height[7:0] = rx_byte;
         parse_phase++;
      end else if (parse_phase == PH_SUM) begin
         if (rx_byte != parse_sum) begin
            parse_phase = PH_HUNT;
            outcome.status = STATUS_SUM;
            emit = 1'b1;
         end else begin
            parse_phase++;
         end
      end else if (parse_phase == PH_END) begin
         parse_phase = PH_HUNT;
         emit = 1'b1;
         if (rx_byte != END_CODE) begin
            outcome.status = STATUS_END;
         end else begin
            parse_armed = 1'b0;
            outcome.status = STATUS_GOOD;
            outcome.height = parse_height;
         end
      end else begin
         parse_phase = PH_HUNT;
         if (rx_byte == START_CODE) begin
            parse_phase = PH_FIXED;
            parse_sum = 8'h00;
            parse_height = 16'h0000;
         end
      end
      if (emit)
         expected_outcomes.push_back(outcome);
   endtask

   function automatic logic random_rearm();
      return ($urandom_range(0, 99) < rearm_percent);
   endfunction

   task automatic send_byte(input logic [7:0] rx_byte, input logic rearm);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = sender_gaps ? $urandom_range(0, 6) : 0;
         repeat (gap) begin
            @(negedge clock);
            req_tvalid = 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = rx_byte;
      req_tuser  = rearm;
      do @(posedge clock); while (!req_tready);
      predict_parse(rx_byte, rearm);
   endtask

   // Frame a body; a nonzero sum_flip corrupts the checksum byte
   task automatic send_packet(input logic [7:0] fixed_byte,
                              input logic [7:0] body [BODY_LEN],
                              input logic [7:0] sum_flip,
                              input logic [7:0] end_byte,
                              input logic       rearm_first);
      logic [7:0] sum;
      sum = FIXED_CODE;
      foreach (body[i])
         sum = sum + body[i];
      send_byte(START_CODE, rearm_first);
      send_byte(fixed_byte, random_rearm());
      if (fixed_byte != FIXED_CODE)
         return;
      foreach (body[i])
         send_byte(body[i], random_rearm());
      send_byte(sum ^ sum_flip, random_rearm());
      if (sum_flip != 8'h00)
         return;
      send_byte(end_byte, random_rearm());
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (expected_outcomes.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_hunting_noise();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      wait_for_results();
   endtask

   task automatic test_good_packet();
      send_packet(FIXED_CODE, '{8'hFF, 8'hFF, 8'hFF}, 8'h00, END_CODE, 1'b0);
      wait_for_results();
   endtask

   task automatic test_disarmed_drop();
      // disarmed after the good frame: these vanish without a trace
      send_byte(START_CODE, 1'b0);
      send_byte(FIXED_CODE, 1'b0);
      wait_for_results();
   endtask

   task automatic test_checksum_mismatch();
      send_packet(FIXED_CODE, '{8'h00, 8'h12, 8'h34}, 8'hFF, END_CODE, 1'b1);
   endtask

   task automatic test_fixed_mismatch();
      // the start byte right after a bad checksum must open a new frame
      send_packet(8'h00, '{8'h00, 8'h00, 8'h00}, 8'h00, END_CODE, 1'b0);
      wait_for_results();
   endtask

   task automatic test_end_mismatch();
      send_packet(FIXED_CODE, '{8'h5A, 8'h00, 8'h00}, 8'h00, 8'hFF, 1'b0);
      wait_for_results();
   endtask

   task automatic random_traffic(input int target);
      logic [7:0] body [BODY_LEN];
      logic [7:0] fixed_byte;
      logic [7:0] end_byte;
      logic [7:0] sum_flip;
      int         start_count;
      int         pick;
      start_count = sent_count;
      while (sent_count - start_count < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            foreach (body[i])
               body[i] = 8'($urandom_range(0, 255));
            fixed_byte = FIXED_CODE;
            sum_flip   = 8'h00;
            end_byte   = END_CODE;
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               fixed_byte = 8'($urandom_range(0, 255));
               if (fixed_byte == FIXED_CODE)
                  fixed_byte = 8'h00;
            end else if (pick == 1) begin
               sum_flip = 8'($urandom_range(1, 255));
            end else if (pick == 2) begin
               end_byte = 8'($urandom_range(0, 255));
               if (end_byte == END_CODE)
                  end_byte = 8'hE9;
            end
            rearm_percent = 3;
            send_packet(fixed_byte, body, sum_flip, end_byte,
                        $urandom_range(0, 9) < 7);
         end else begin
            rearm_percent = 10;
            repeat ($urandom_range(1, 4))
               send_byte(8'($urandom_range(0, 255)), random_rearm());
         end
         if ($urandom_range(0, 39) == 0)
            wait_for_results();
      end
      wait_for_results();
   endtask

   task automatic test_random_back_to_back();
      sender_gaps = 1'b0;
      rsp_stalls  = 1'b0;
      random_traffic(250);
   endtask

   task automatic test_random_with_idling();
      sender_gaps = 1'b1;
      rsp_stalls  = 1'b1;
      random_traffic(1400);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_hunting_noise();
      test_good_packet();
      test_disarmed_drop();
      test_checksum_mismatch();
      test_fixed_mismatch();
      test_end_mismatch();
      test_random_back_to_back();
      test_random_with_idling();

      // allow for stray late transfers
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_outcomes.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/fhpp_pkg.sv
rtl/fhpp_parse.sv
rtl/framed_height_packet_parser.sv
tb/sv/framed_height_packet_parser_tb.sv
